>>> src/rtr_pkg.sv
package rtr_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int IDX_BITS  = COL_BITS + 1;

    localparam logic signed [15:0] END_MARK   = 16'sd32767;
    localparam logic [14:0]        PLAIN_SIZE = 15'd10;

    localparam logic [1:0] KIND_RECT = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_WIDE = 2'd2;

    typedef logic signed [15:0] coord_t;

endpackage

>>> src/rtr_item_if.sv
interface rtr_item_if;
    import rtr_pkg::*;

    logic        valid;
    logic        ready;
    logic        mode;
    logic [14:0] region_size;
    coord_t      box_left;
    coord_t      box_top;
    coord_t      box_right;
    coord_t      box_bottom;
    coord_t      data_word;

    modport source (
        output valid, mode, region_size, box_left, box_top, box_right, box_bottom,
               data_word,
        input  ready
    );

    modport sink (
        input  valid, mode, region_size, box_left, box_top, box_right, box_bottom,
               data_word,
        output ready
    );

endinterface

>>> src/rtr_result_if.sv
interface rtr_result_if;
    import rtr_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] kind;
    coord_t     rect_left;
    coord_t     rect_top;
    coord_t     rect_right;
    coord_t     rect_bottom;
    logic       last;

    modport source (
        output valid, kind, rect_left, rect_top, rect_right, rect_bottom, last,
        input  ready
    );

    modport sink (
        input  valid, kind, rect_left, rect_top, rect_right, rect_bottom, last,
        output ready
    );

endinterface

>>> src/rtr_ram.sv
module rtr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/region_to_rectangles.sv
// region_to_rectangles
// Decodes a scanline-encoded region into rectangles.
// Channels: item (sink) takes one word per handshake, either a header
// (mode 0: size word and bounding box) or a region data word (mode 1).
// result (source) gives rectangles, a region-finished word or a
// region-too-wide word; last marks the final result caused by one item.
// A header, y, x1 or end-mark word is handled when it is accepted; its
// result (if any) is visible in the output register the cycle after.
// An x2 word walks the run's columns through the shared column-top store:
// each column is read (S_READ) and compared (S_EVAL), each rectangle closed
// passes through S_PUSH (when the group ends inside the run, the next column
// is read again after it) and S_FLUSH finishes the run.
// item.ready is low during the walk and while an undelivered result
// blocks the output register; a stalled receiver stalls the walk.
// Reset (rst_n low, asynchronous) returns the parser to idle and marks
// every column top as empty (32767); no clearing pass is needed.
module region_to_rectangles
    import rtr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rtr_item_if.sink     item,
    rtr_result_if.source result
);

    typedef enum logic [1:0] { PH_IDLE, PH_Y, PH_X1, PH_X2 } phase_t;
    typedef enum logic [2:0] { S_IDLE, S_READ, S_EVAL, S_PUSH, S_FLUSH } state_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    coord_t                x_origin_reg, x_origin_next;
    coord_t                line_y_reg, line_y_next;
    coord_t                run_start_reg, run_start_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [IDX_BITS-1:0]   hi_reg, hi_next;
    logic                  grp_active_reg, grp_active_next;
    coord_t                grp_left_reg, grp_left_next;
    coord_t                grp_top_reg, grp_top_next;
    logic                  pend_valid_reg, pend_valid_next;
    coord_t                pend_left_reg, pend_left_next;
    coord_t                pend_top_reg, pend_top_next;
    coord_t                pend_right_reg, pend_right_next;
    logic [MAX_WIDTH-1:0]  col_valid_reg, col_valid_next;
    logic                  rd_valid_reg, rd_valid_next;

    logic                  ovalid_reg, ovalid_next;
    logic [1:0]            okind_reg, okind_next;
    coord_t                oleft_reg, oleft_next;
    coord_t                otop_reg, otop_next;
    coord_t                oright_reg, oright_next;
    coord_t                obottom_reg, obottom_next;
    logic                  olast_reg, olast_next;

    logic                  out_free;
    logic                  accept;
    logic                  ram_we;
    coord_t                ram_wdata;
    logic [15:0]           ram_rdata;
    coord_t                col_top;
    logic [IDX_BITS-1:0]   idx_inc;
    logic                  at_end;
    coord_t                x_cur;

    logic signed [17:0]    box_w;
    logic signed [17:0]    lo_off;
    logic signed [17:0]    hi_raw;
    logic signed [17:0]    lo_clip;
    logic signed [17:0]    hi_clip;

    rtr_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg[COL_BITS-1:0]),
        .wdata (ram_wdata),
        .raddr (idx_reg[COL_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free    = !ovalid_reg || result.ready;
    assign item.ready  = (state_reg == S_IDLE) && out_free;
    assign accept      = item.valid && item.ready;

    assign col_top = rd_valid_reg ? coord_t'(ram_rdata) : END_MARK;
    assign idx_inc = idx_reg + IDX_BITS'(1);
    assign at_end  = (idx_inc == hi_reg);
    assign x_cur   = x_origin_reg + coord_t'({{(16-IDX_BITS){1'b0}}, idx_reg});

    assign box_w   = 18'(item.box_right) - 18'(item.box_left);
    assign lo_off  = 18'(run_start_reg) - 18'(x_origin_reg);
    assign hi_raw  = 18'(item.data_word) - 18'(x_origin_reg);
    assign lo_clip = (lo_off < 18'sd0) ? 18'sd0 : lo_off;
    assign hi_clip = (hi_raw > 18'(MAX_WIDTH)) ? 18'(MAX_WIDTH) : hi_raw;

    assign result.valid       = ovalid_reg;
    assign result.kind        = okind_reg;
    assign result.rect_left   = oleft_reg;
    assign result.rect_top    = otop_reg;
    assign result.rect_right  = oright_reg;
    assign result.rect_bottom = obottom_reg;
    assign result.last        = olast_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        x_origin_next   = x_origin_reg;
        line_y_next     = line_y_reg;
        run_start_next  = run_start_reg;
        idx_next        = idx_reg;
        hi_next         = hi_reg;
        grp_active_next = grp_active_reg;
        grp_left_next   = grp_left_reg;
        grp_top_next    = grp_top_reg;
        pend_valid_next = pend_valid_reg;
        pend_left_next  = pend_left_reg;
        pend_top_next   = pend_top_reg;
        pend_right_next = pend_right_reg;
        col_valid_next  = col_valid_reg;
        rd_valid_next   = rd_valid_reg;

        ovalid_next     = ovalid_reg && !result.ready;
        okind_next      = okind_reg;
        oleft_next      = oleft_reg;
        otop_next       = otop_reg;
        oright_next     = oright_reg;
        obottom_next    = obottom_reg;
        olast_next      = olast_reg;

        ram_we          = 1'b0;
        ram_wdata       = END_MARK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!item.mode)
                    begin
                        phase_next = PH_IDLE;
                        if (item.region_size == PLAIN_SIZE)
                        begin
                            ovalid_next  = 1'b1;
                            okind_next   = KIND_RECT;
                            oleft_next   = item.box_left;
                            otop_next    = item.box_top;
                            oright_next  = item.box_right;
                            obottom_next = item.box_bottom;
                            olast_next   = 1'b1;
                        end
                        else if (box_w > 18'(MAX_WIDTH))
                        begin
                            ovalid_next  = 1'b1;
                            okind_next   = KIND_WIDE;
                            oleft_next   = '0;
                            otop_next    = '0;
                            oright_next  = '0;
                            obottom_next = '0;
                            olast_next   = 1'b1;
                        end
                        else
                        begin
                            x_origin_next  = item.box_left;
                            col_valid_next = '0;
                            phase_next     = PH_Y;
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_Y:
                            begin
                                if (item.data_word == END_MARK)
                                begin
                                    ovalid_next  = 1'b1;
                                    okind_next   = KIND_DONE;
                                    oleft_next   = '0;
                                    otop_next    = '0;
                                    oright_next  = '0;
                                    obottom_next = '0;
                                    olast_next   = 1'b1;
                                    phase_next   = PH_IDLE;
                                end
                                else
                                begin
                                    line_y_next = item.data_word;
                                    phase_next  = PH_X1;
                                end
                            end
                            PH_X1:
                            begin
                                if (item.data_word == END_MARK)
                                begin
                                    phase_next = PH_Y;
                                end
                                else
                                begin
                                    run_start_next = item.data_word;
                                    phase_next     = PH_X2;
                                end
                            end
                            PH_X2:
                            begin
                                phase_next = PH_X1;
                                if (lo_clip < hi_clip)
                                begin
                                    idx_next        = lo_clip[IDX_BITS-1:0];
                                    hi_next         = hi_clip[IDX_BITS-1:0];
                                    grp_active_next = 1'b0;
                                    pend_valid_next = 1'b0;
                                    state_next      = S_READ;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_READ:
            begin
                rd_valid_next = col_valid_reg[idx_reg[COL_BITS-1:0]];
                state_next    = S_EVAL;
            end

            S_EVAL:
            begin
                if (!grp_active_reg)
                begin
                    ram_we = 1'b1;
                    col_valid_next[idx_reg[COL_BITS-1:0]] = 1'b1;
                    idx_next = idx_inc;
                    if (col_top < line_y_reg)
                    begin
                        ram_wdata       = END_MARK;
                        grp_active_next = 1'b1;
                        grp_left_next   = x_cur;
                        grp_top_next    = col_top;
                        state_next      = at_end ? S_PUSH : S_READ;
                    end
                    else
                    begin
                        ram_wdata  = line_y_reg;
                        state_next = at_end ? S_FLUSH : S_READ;
                    end
                end
                else if (col_top == grp_top_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = END_MARK;
                    col_valid_next[idx_reg[COL_BITS-1:0]] = 1'b1;
                    idx_next   = idx_inc;
                    state_next = at_end ? S_PUSH : S_READ;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        ovalid_next  = 1'b1;
                        okind_next   = KIND_RECT;
                        oleft_next   = pend_left_reg;
                        otop_next    = pend_top_reg;
                        oright_next  = pend_right_reg;
                        obottom_next = line_y_reg;
                        olast_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_left_next  = grp_left_reg;
                    pend_top_next   = grp_top_reg;
                    pend_right_next = x_cur;
                    grp_active_next = 1'b0;
                    state_next      = (idx_reg == hi_reg) ? S_FLUSH : S_READ;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        ovalid_next  = 1'b1;
                        okind_next   = KIND_RECT;
                        oleft_next   = pend_left_reg;
                        otop_next    = pend_top_reg;
                        oright_next  = pend_right_reg;
                        obottom_next = line_y_reg;
                        olast_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            x_origin_reg   <= '0;
            line_y_reg     <= '0;
            run_start_reg  <= '0;
            idx_reg        <= '0;
            hi_reg         <= '0;
            grp_active_reg <= 1'b0;
            grp_left_reg   <= '0;
            grp_top_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_left_reg  <= '0;
            pend_top_reg   <= '0;
            pend_right_reg <= '0;
            col_valid_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            ovalid_reg     <= 1'b0;
            okind_reg      <= KIND_RECT;
            oleft_reg      <= '0;
            otop_reg       <= '0;
            oright_reg     <= '0;
            obottom_reg    <= '0;
            olast_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            x_origin_reg   <= x_origin_next;
            line_y_reg     <= line_y_next;
            run_start_reg  <= run_start_next;
            idx_reg        <= idx_next;
            hi_reg         <= hi_next;
            grp_active_reg <= grp_active_next;
            grp_left_reg   <= grp_left_next;
            grp_top_reg    <= grp_top_next;
            pend_valid_reg <= pend_valid_next;
            pend_left_reg  <= pend_left_next;
            pend_top_reg   <= pend_top_next;
            pend_right_reg <= pend_right_next;
            col_valid_reg  <= col_valid_next;
            rd_valid_reg   <= rd_valid_next;
            ovalid_reg     <= ovalid_next;
            okind_reg      <= okind_next;
            oleft_reg      <= oleft_next;
            otop_reg       <= otop_next;
            oright_reg     <= oright_next;
            obottom_reg    <= obottom_next;
            olast_reg      <= olast_next;
        end
    end

endmodule
